### hdl/assert_macros.svh
// Assertion macros shared by the heater controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define HPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a result in the next cycle.
`define HPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HPC_ASSERT(lbl, prop, msg)
`define HPC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/hpc_pkg.sv
// Shared types and constants of the heater power controller.
package hpc_pkg;

    localparam int IntegralBits = 48;
    localparam int TempW        = 16;
    localparam int DtW          = 16;
    localparam int PowW         = 16;
    localparam int GainW        = 24;
    localparam int BandW        = 12;
    localparam int ErrW         = TempW + 1;
    localparam int DerrW        = ErrW + 1;
    localparam int IncW         = ErrW + DtW + 1;
    localparam int MulAW        = GainW;
    localparam int IhiW         = IntegralBits - MulAW;
    localparam int MulBW        = (IhiW > MulAW) ? IhiW : MulAW;
    localparam int ProdW        = MulAW + MulBW;
    localparam int SatBit       = 62;
    localparam int MagW         = (MulAW + IntegralBits > SatBit + 1) ?
                                  MulAW + IntegralBits : SatBit + 1;
    localparam int SumW         = SatBit + 3;
    localparam int FracBits     = 12;
    localparam int RawW         = SumW - FracBits;
    localparam int DivW         = GainW + DerrW - 1;
    localparam int DivCntW      = $clog2(DivW);
    localparam int SatAddW      = ((IntegralBits > IncW) ? IntegralBits : IncW) + 1;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 24;
    localparam int InDataW      = 3 * TempW;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MODE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BAND    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_PWR = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MAX_PWR = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_P  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D  = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE, ST_CLEAR, ST_HYST, ST_MINC, ST_INTEG, ST_MILO, ST_MIHI,
        ST_ADDI, ST_MULP, ST_ADDP, ST_MULD, ST_DSTART, ST_DSTEP, ST_ADDD, ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_HYST, OP_MINC, OP_INTEG, OP_MILO, OP_MIHI, OP_ADDI,
        OP_MULP, OP_ADDP, OP_MULD, OP_DSTART, OP_DSTEP, OP_ADDD, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take_in;
        logic load_out;
    } hpc_cmd_t;

    typedef struct packed {
        logic clear_req;
        logic pid_mode;
        logic dterm_en;
        logic out_free;
    } hpc_sts_t;

endpackage

### hdl/hpc_ctrl.sv
// Sequencer that steps the datapath through one control update.
`include "assert_macros.svh"
module hpc_ctrl
    import hpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  hpc_sts_t sts,
    output hpc_cmd_t cmd
);

    state_t              state_reg, state_next;
    logic [DivCntW-1:0]  cnt_reg, cnt_next;

    // Hold state and divide step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance through the update sequence
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (sts.clear_req)     state_next = ST_CLEAR;
                else if (sts.pid_mode) state_next = ST_MINC;
                else                   state_next = ST_HYST;
            end
            ST_CLEAR:  state_next = ST_OUT;
            ST_HYST:   state_next = ST_OUT;
            ST_MINC:   state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_MILO;
            ST_MILO:   state_next = ST_MIHI;
            ST_MIHI:   state_next = ST_ADDI;
            ST_ADDI:   state_next = ST_MULP;
            ST_MULP:   state_next = ST_ADDP;
            ST_ADDP:   state_next = ST_MULD;
            ST_MULD:   state_next = ST_DSTART;
            ST_DSTART: state_next = sts.dterm_en ? ST_DSTEP : ST_FINISH;
            ST_DSTEP:
            begin
                if (cnt_reg == DivCntW'(DivW - 1)) state_next = ST_ADDD;
                else                               cnt_next   = cnt_reg + 1'b1;
            end
            ST_ADDD:   state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '{op: OP_NONE, take_in: 1'b0, load_out: 1'b0};
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
            end
            ST_CLEAR:  cmd.op = OP_CLEAR;
            ST_HYST:   cmd.op = OP_HYST;
            ST_MINC:   cmd.op = OP_MINC;
            ST_INTEG:  cmd.op = OP_INTEG;
            ST_MILO:   cmd.op = OP_MILO;
            ST_MIHI:   cmd.op = OP_MIHI;
            ST_ADDI:   cmd.op = OP_ADDI;
            ST_MULP:   cmd.op = OP_MULP;
            ST_ADDP:   cmd.op = OP_ADDP;
            ST_MULD:   cmd.op = OP_MULD;
            ST_DSTART: cmd.op = OP_DSTART;
            ST_DSTEP:  cmd.op = OP_DSTEP;
            ST_ADDD:   cmd.op = OP_ADDD;
            ST_FINISH: cmd.op = OP_FINISH;
            ST_OUT:    cmd.load_out = sts.out_free;
            default:   cmd.op = OP_NONE;
        endcase
    end

    `HPC_ASSERT(a_load_free, !cmd.load_out || sts.out_free, "result loaded over a pending word")
    `HPC_ASSERT_NEXT(a_skip_div, (state_reg == ST_DSTART) && !sts.dterm_en, state_reg == ST_FINISH, "divide not skipped")
    `HPC_ASSERT(a_cnt_range, (state_reg != ST_DSTEP) || (cnt_reg < DivCntW'(DivW)), "divide count overrun")

endmodule

### hdl/hpc_dpath.sv
// Datapath: configuration, controller state, shared multiplier and serial divider.
module hpc_dpath
    import hpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hpc_cmd_t            cmd,
    output hpc_sts_t            sts,
    input  logic [InDataW-1:0]  in_data,
    input  logic                in_clear,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PowW-1:0]     out_power,
    output logic                out_limited
);

    // Configuration
    logic                     mode_reg;
    logic [BandW-1:0]         band_reg;
    logic signed [PowW-1:0]   min_reg, max_reg;
    logic signed [GainW-1:0]  gp_reg, gi_reg, gd_reg;

    // Controller state
    logic signed [IntegralBits-1:0] int_reg, before_reg;
    logic signed [ErrW-1:0]   last_err_reg;
    logic                     last_valid_reg, heater_reg;

    // Working registers
    logic signed [ErrW-1:0]   err_reg;
    logic [DtW-1:0]           dt_reg;
    logic                     clr_reg;
    logic [ProdW-1:0]         prod_reg;
    logic [2*MulAW-1:0]       lo_reg;
    logic signed [SumW-1:0]   sum_reg;
    logic [DivW-1:0]          quo_reg;
    logic [DtW-1:0]           rem_reg;
    logic signed [PowW-1:0]   res_power_reg;
    logic                     res_lim_reg;
    logic                     out_valid_reg;
    logic signed [PowW-1:0]   out_power_reg;
    logic                     out_lim_reg;

    logic signed [TempW-1:0]  in_meas, in_targ;
    logic [ErrW-1:0]          err_mag;
    logic signed [DerrW-1:0]  derr;
    logic [DerrW-1:0]         derr_mag;
    logic [IntegralBits-1:0]  int_mag;
    logic [GainW-1:0]         gp_mag, gi_mag, gd_mag;
    logic [MulAW-1:0]         mul_a;
    logic [MulBW-1:0]         mul_b;
    logic signed [IncW-1:0]   inc;
    logic signed [SatAddW-1:0] isum, int_hi, int_lo;
    logic signed [IntegralBits-1:0] int_new;
    logic [MagW-1:0]          imag, isat;
    logic signed [SumW-1:0]   iterm, pterm, dterm;
    logic signed [SumW-1:0]   rq;
    logic signed [RawW-1:0]   raw, min_x, max_x;
    logic                     lim_lo, lim_hi;
    logic signed [PowW-1:0]   pid_power;
    logic signed [DerrW-1:0]  err2, band_p, band_n;
    logic                     heater_new;
    logic [DtW:0]             trial;
    logic                     ge;

    function automatic logic signed [PowW-1:0] clamp_pow(
        input logic signed [PowW-1:0] v,
        input logic signed [PowW-1:0] lo,
        input logic signed [PowW-1:0] hi
    );
        if (v < lo)      return lo;
        else if (v > hi) return hi;
        else             return v;
    endfunction

    assign in_meas = in_data[TempW-1:0];
    assign in_targ = in_data[2*TempW-1:TempW];

    // Magnitudes of signed operands
    assign err_mag  = err_reg[ErrW-1] ? ErrW'(-err_reg) : ErrW'(err_reg);
    assign derr     = DerrW'(err_reg) - DerrW'(last_err_reg);
    assign derr_mag = derr[DerrW-1] ? DerrW'(-derr) : DerrW'(derr);
    assign int_mag  = int_reg[IntegralBits-1] ? IntegralBits'(-int_reg)
                                              : IntegralBits'(int_reg);
    assign gp_mag   = gp_reg[GainW-1] ? GainW'(-gp_reg) : GainW'(gp_reg);
    assign gi_mag   = gi_reg[GainW-1] ? GainW'(-gi_reg) : GainW'(gi_reg);
    assign gd_mag   = gd_reg[GainW-1] ? GainW'(-gd_reg) : GainW'(gd_reg);

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MINC:
            begin
                mul_a = MulAW'(err_mag);
                mul_b = MulBW'(dt_reg);
            end
            OP_MILO:
            begin
                mul_a = gi_mag;
                mul_b = MulBW'(int_mag[MulAW-1:0]);
            end
            OP_MIHI:
            begin
                mul_a = gi_mag;
                mul_b = MulBW'(int_mag[IntegralBits-1:MulAW]);
            end
            OP_MULP:
            begin
                mul_a = gp_mag;
                mul_b = MulBW'(err_mag);
            end
            OP_MULD:
            begin
                mul_a = gd_mag;
                mul_b = MulBW'(derr_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturating integral update
    assign inc    = err_reg[ErrW-1] ? -IncW'(prod_reg[ErrW+DtW-1:0])
                                    : IncW'(prod_reg[ErrW+DtW-1:0]);
    assign int_hi = {{(SatAddW-IntegralBits+1){1'b0}}, {(IntegralBits-1){1'b1}}};
    assign int_lo = ~int_hi;
    assign isum   = SatAddW'(int_reg) + SatAddW'(inc);
    assign int_new = (isum > int_hi) ? IntegralBits'(int_hi) :
                     (isum < int_lo) ? IntegralBits'(int_lo) : IntegralBits'(isum);

    // Integral term from two partial products, saturated
    assign imag  = (MagW'(prod_reg) << MulAW) + MagW'(lo_reg);
    assign isat  = (imag > (MagW'(1) << SatBit)) ? (MagW'(1) << SatBit) : imag;
    assign iterm = (gi_reg[GainW-1] ^ int_reg[IntegralBits-1]) ? -SumW'(isat)
                                                                : SumW'(isat);
    assign pterm = (gp_reg[GainW-1] ^ err_reg[ErrW-1]) ? -SumW'(prod_reg)
                                                        : SumW'(prod_reg);
    assign dterm = (gd_reg[GainW-1] ^ derr[DerrW-1]) ? -SumW'(quo_reg)
                                                      : SumW'(quo_reg);

    // Restoring divide step
    assign trial = {rem_reg, quo_reg[DivW-1]};
    assign ge    = trial >= {1'b0, dt_reg};

    // Round, then clamp
    assign rq        = sum_reg + SumW'(2048);
    assign raw       = rq[SumW-1:FracBits];
    assign min_x     = RawW'(min_reg);
    assign max_x     = RawW'(max_reg);
    assign lim_lo    = raw < min_x;
    assign lim_hi    = raw > max_x;
    assign pid_power = lim_lo ? min_reg : lim_hi ? max_reg : raw[PowW-1:0];

    // Hysteresis switching
    assign err2       = {err_reg, 1'b0};
    assign band_p     = DerrW'(band_reg);
    assign band_n     = -band_p;
    assign heater_new = (err2 > band_p) ? 1'b1 : (err2 < band_n) ? 1'b0 : heater_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            band_reg <= BandW'(32);
            min_reg  <= '0;
            max_reg  <= PowW'(25600);
            gp_reg   <= '0;
            gi_reg   <= '0;
            gd_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    mode_reg <= cfg_data[0];
                CFG_BAND:    band_reg <= cfg_data[BandW-1:0];
                CFG_MIN_PWR: min_reg  <= cfg_data[PowW-1:0];
                CFG_MAX_PWR: max_reg  <= cfg_data[PowW-1:0];
                CFG_GAIN_P:  gp_reg   <= cfg_data[GainW-1:0];
                CFG_GAIN_I:  gi_reg   <= cfg_data[GainW-1:0];
                CFG_GAIN_D:  gd_reg   <= cfg_data[GainW-1:0];
                default:     mode_reg <= mode_reg;
            endcase
        end
    end

    // Controller state and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg        <= '0;
            last_err_reg   <= '0;
            last_valid_reg <= 1'b0;
            heater_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    int_reg        <= '0;
                    last_err_reg   <= '0;
                    last_valid_reg <= 1'b0;
                    heater_reg     <= 1'b0;
                end
                OP_HYST:  heater_reg <= heater_new;
                OP_INTEG: int_reg    <= int_new;
                OP_FINISH:
                begin
                    if ((lim_lo || lim_hi) && (gi_reg != '0)) int_reg <= before_reg;
                    last_err_reg   <= err_reg;
                    last_valid_reg <= 1'b1;
                end
                default: heater_reg <= heater_reg;
            endcase
            if (cmd.load_out)  out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            err_reg <= ErrW'(in_targ) - ErrW'(in_meas);
            dt_reg  <= in_data[InDataW-1:2*TempW];
            clr_reg <= in_clear;
        end
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_CLEAR:
            begin
                res_power_reg <= '0;
                res_lim_reg   <= 1'b0;
            end
            OP_HYST:
            begin
                res_power_reg <= clamp_pow(heater_new ? max_reg : min_reg, min_reg, max_reg);
                res_lim_reg   <= 1'b0;
            end
            OP_MINC:   before_reg <= int_reg;
            OP_MIHI:   lo_reg     <= prod_reg[2*MulAW-1:0];
            OP_ADDI:   sum_reg    <= iterm;
            OP_ADDP:   sum_reg    <= sum_reg + pterm;
            OP_DSTART:
            begin
                quo_reg <= prod_reg[DivW-1:0];
                rem_reg <= '0;
            end
            OP_DSTEP:
            begin
                rem_reg <= ge ? DtW'(trial - {1'b0, dt_reg}) : trial[DtW-1:0];
                quo_reg <= {quo_reg[DivW-2:0], ge};
            end
            OP_ADDD:   sum_reg <= sum_reg + dterm;
            OP_FINISH:
            begin
                res_power_reg <= pid_power;
                res_lim_reg   <= lim_lo || lim_hi;
            end
            default:   lo_reg <= lo_reg;
        endcase
        if (cmd.load_out)
        begin
            out_power_reg <= res_power_reg;
            out_lim_reg   <= res_lim_reg;
        end
    end

    assign sts.clear_req = clr_reg;
    assign sts.pid_mode  = mode_reg;
    assign sts.dterm_en  = last_valid_reg && (dt_reg != '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_power   = out_power_reg;
    assign out_limited = out_lim_reg;

endmodule

### hdl/heater_pid_or_hysteresis_control_unit.sv
// Heater power controller: on/off hysteresis or PID, top level.
// One sample is taken at a time. The length of a PID update is set by the
// 41-step serial divider of the derivative term and by the single shared
// 24-bit multiplier used for the integral, gain and derivative products. The
// divider is skipped on the first sample after reset or a clear, and on a zero
// time step. The input is ready again in the cycle after the result is loaded,
// so the next sample is taken only once the result has been loaded. A finished
// result waits before loading while the previous word is still held on the
// output.
module heater_pid_or_hysteresis_control_unit
    import hpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // measured_temp, target_temp, time_step
    input  logic [0:0]          s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PowW-1:0]     m_tdata,   // drive_power
    output logic [0:0]          m_tuser,   // was_limited
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    hpc_cmd_t cmd;
    hpc_sts_t sts;

    hpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hpc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (s_tdata),
        .in_clear    (s_tuser[0]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_power   (m_tdata),
        .out_limited (m_tuser[0])
    );

endmodule
